### hw/rtl/crx_pkg.sv
// Package for the colour run explorer: word types, register indexes, class codes.
// No dependencies; crx_front, crx_back and color_run_explorer_unit import it.
package crx_pkg;

	localparam int CW = 14;
	typedef logic signed [CW-1:0] crd_t;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_EXPLORE = 1'b1;

	localparam logic [1:0] CLS_NONE   = 2'd0;
	localparam logic [1:0] CLS_ORANGE = 2'd1;
	localparam logic [1:0] CLS_WHITE  = 2'd2;
	localparam logic [1:0] CLS_GREEN  = 2'd3;

	localparam int IDX_W = 3;
	localparam logic [IDX_W-1:0] REG_EXPLORE_STEP   = 3'd0;
	localparam logic [IDX_W-1:0] REG_GRID_STEP      = 3'd1;
	localparam logic [IDX_W-1:0] REG_SKIP_OFFSET    = 3'd2;
	localparam logic [IDX_W-1:0] REG_MIN_SEG_ORANGE = 3'd3;
	localparam logic [IDX_W-1:0] REG_MIN_SEG_WHITE  = 3'd4;

	localparam logic [11:0] SIZE_MAX = 12'd4095;

	typedef struct packed {
		logic       op;
		logic [8:0] pos_x;
		logic [7:0] pos_y;
		logic [1:0] pixel_class;
		logic [1:0] run_color;
		logic [8:0] left_limit;
		logic [8:0] bottom_limit;
		logic [7:0] top_limit;
	} cmd_t;

	typedef struct packed {
		logic [11:0] run_size;
		logic        rejected;
		logic [8:0]  run_end_row;
		logic [7:0]  extent_top;
		logic [8:0]  extent_bottom;
	} res_t;

	typedef struct packed {
		logic [6:0] explore_step;
		logic [4:0] grid_step;
		logic [4:0] skip_offset;
		logic [7:0] min_seg_orange;
		logic [7:0] min_seg_white;
	} cfg_t;

	typedef struct packed {
		logic ram_we;
		logic ram_re;
	} bk_stat_t;

endpackage

### hw/rtl/crx_if.sv
// Channel interfaces of the colour run explorer: command words in, result words out.
// Depends on nothing; fields follow the word layout of crx_pkg.
interface crx_cmd_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [8:0] pos_x;
	logic [7:0] pos_y;
	logic [1:0] pixel_class;
	logic [1:0] run_color;
	logic [8:0] left_limit;
	logic [8:0] bottom_limit;
	logic [7:0] top_limit;

	modport source (output valid, op, pos_x, pos_y, pixel_class, run_color, left_limit,
		bottom_limit, top_limit, input ready);
	modport sink (input valid, op, pos_x, pos_y, pixel_class, run_color, left_limit,
		bottom_limit, top_limit, output ready);
endinterface

interface crx_res_if;
	logic        valid;
	logic        ready;
	logic [11:0] run_size;
	logic        rejected;
	logic [8:0]  run_end_row;
	logic [7:0]  extent_top;
	logic [8:0]  extent_bottom;

	modport source (output valid, run_size, rejected, run_end_row, extent_top,
		extent_bottom, input ready);
	modport sink (input valid, run_size, rejected, run_end_row, extent_top,
		extent_bottom, output ready);
endinterface

### hw/rtl/crx_ram.sv
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module crx_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 131072
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### hw/rtl/crx_front.sv
// Front end: accepts command words and queues them for the back end.
// Depends on crx_pkg and crx_cmd_if.
module crx_front #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	crx_cmd_if.sink       cmd,
	output logic          q_valid,
	output crx_pkg::cmd_t q_item,
	input  logic          q_pop
);
	import crx_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	cmd_t          buf_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          push, pop;
	cmd_t          in_word;

	assign in_word = '{op: cmd.op, pos_x: cmd.pos_x, pos_y: cmd.pos_y,
		pixel_class: cmd.pixel_class, run_color: cmd.run_color, left_limit: cmd.left_limit,
		bottom_limit: cmd.bottom_limit, top_limit: cmd.top_limit};

	assign cmd.ready = (count_q != NW'(DEPTH));
	assign push      = cmd.valid && cmd.ready;
	assign q_valid   = (count_q != '0);
	assign pop       = q_pop && q_valid;
	assign q_item    = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

### hw/rtl/crx_back.sv
// Back end: executes pixel writes and column run exploration over the class frame.
// Depends on crx_pkg and crx_ram.
module crx_back #(
	parameter int FRAME_WIDTH  = 512,
	parameter int FRAME_HEIGHT = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  crx_pkg::cfg_t     cfg,
	input  logic              q_valid,
	input  crx_pkg::cmd_t     q_item,
	output logic              q_pop,
	output logic              res_valid,
	output crx_pkg::res_t     res_word,
	input  logic              res_ready,
	output crx_pkg::bk_stat_t stat
);
	import crx_pkg::*;

	localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_SCHK = 13'b0000000000010,
		ST_ST1  = 13'b0000000000100,
		ST_SINR = 13'b0000000001000,
		ST_ST2  = 13'b0000000010000,
		ST_RUN  = 13'b0000000100000,
		ST_LCHK = 13'b0000001000000,
		ST_LTOP = 13'b0000010000000,
		ST_RUP  = 13'b0000100000000,
		ST_LBRD = 13'b0001000000000,
		ST_LBOT = 13'b0010000000000,
		ST_RDN  = 13'b0100000000000,
		ST_DONE = 13'b1000000000000
	} state_t;

	state_t      state_q, ret_q;
	crd_t        y_q, back_q, sx_q, send_q, e_q;
	logic        dir_q;
	crd_t        x0_q, y0_q, xmin_q, yend_q, ymin_q, cx_q, top_q, bot_q, runend_q;
	logic [1:0]  col_q;
	logic        pok_q, res_valid_q;
	logic [11:0] size_q;
	logic        rej_q;
	res_t        res_q;

	crd_t        s_c, stp_c, fwd_c, unit_c, fin_y_c, clip_c, rx, ry, len_c, minlen_c;
	logic        before_c, match_c, re, we, rd_ok;
	logic [1:0]  rdata;
	logic [AW-1:0] raddr, waddr;
	logic [14:0] prod_c;
	logic [11:0] size_c;

	assign s_c    = crd_t'((cfg.skip_offset == '0) ? 5'd1 : cfg.skip_offset);
	assign stp_c  = crd_t'((cfg.explore_step == '0) ? 7'd1 : cfg.explore_step);
	assign fwd_c  = dir_q ? -s_c : s_c;
	assign unit_c = dir_q ? crd_t'(-1) : crd_t'(1);
	assign before_c = dir_q ? (y_q > send_q) : (y_q < send_q);
	assign match_c  = pok_q ? (rdata == col_q) : (col_q == CLS_NONE);
	assign fin_y_c  = (state_q == ST_SINR) ? y_q + unit_c : y_q;
	assign clip_c   = dir_q ? ((fin_y_c < send_q) ? send_q : fin_y_c)
	                        : ((fin_y_c > send_q) ? send_q : fin_y_c);

	assign len_c  = e_q - y0_q;
	assign prod_c = 15'(len_c[9:0]) * 15'(cfg.grid_step);
	assign size_c = len_c[CW-1] ? 12'd0 : ((prod_c > 15'(SIZE_MAX)) ? SIZE_MAX : prod_c[11:0]);

	always_comb begin
		case (col_q)
			CLS_ORANGE: minlen_c = crd_t'(cfg.min_seg_orange);
			CLS_WHITE:  minlen_c = crd_t'(cfg.min_seg_white);
			default:    minlen_c = '0;
		endcase
	end

	always_comb begin
		re = 1'b0;
		rx = sx_q;
		ry = y_q;
		case (state_q)
			ST_SCHK: re = before_c;
			ST_SINR: re = (y_q != back_q);
			ST_LCHK: begin
				re = (cx_q > xmin_q);
				rx = cx_q;
				ry = top_q;
			end
			ST_LBRD: begin
				re = 1'b1;
				rx = cx_q;
				ry = bot_q;
			end
			default: re = 1'b0;
		endcase
	end

	assign rd_ok = (rx >= 0) && (rx < crd_t'(FRAME_WIDTH)) && (ry >= 0)
		&& (ry < crd_t'(FRAME_HEIGHT));
	assign raddr = AW'(ry[11:0] * FRAME_WIDTH + rx[11:0]);
	assign waddr = AW'(q_item.pos_y * FRAME_WIDTH + q_item.pos_x);
	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign we    = q_pop && (q_item.op == OP_WRITE) && (int'(q_item.pos_x) < FRAME_WIDTH)
		&& (int'(q_item.pos_y) < FRAME_HEIGHT);

	assign stat      = '{ram_we: we, ram_re: re};
	assign res_valid = res_valid_q;
	assign res_word  = res_q;

	crx_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_frame (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (q_item.pixel_class),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		pok_q <= rd_ok;
		case (state_q)
			ST_IDLE: begin
				if (q_pop && q_item.op == OP_EXPLORE) begin
					x0_q   <= crd_t'(q_item.pos_x);
					y0_q   <= crd_t'(q_item.pos_y);
					col_q  <= q_item.run_color;
					xmin_q <= crd_t'(q_item.left_limit);
					yend_q <= crd_t'(q_item.bottom_limit);
					ymin_q <= crd_t'(q_item.top_limit);
					y_q    <= crd_t'(q_item.pos_y) + s_c;
					dir_q  <= 1'b0;
					sx_q   <= crd_t'(q_item.pos_x);
					send_q <= crd_t'(q_item.bottom_limit);
				end
			end
			ST_SCHK: begin
				if (!before_c) begin
					e_q <= clip_c;
				end
			end
			ST_ST1: begin
				if (match_c) begin
					y_q <= y_q + fwd_c;
				end else begin
					back_q <= y_q - fwd_c;
					y_q    <= y_q - unit_c;
				end
			end
			ST_SINR: begin
				if (y_q == back_q) begin
					e_q <= clip_c;
				end
			end
			ST_ST2: begin
				y_q <= match_c ? y_q + fwd_c : y_q - unit_c;
			end
			ST_RUN: begin
				runend_q <= e_q;
				top_q    <= y0_q;
				size_q   <= size_c;
				rej_q    <= 1'b0;
				cx_q     <= x0_q - stp_c;
				if (col_q == CLS_GREEN) begin
					bot_q <= e_q;
				end else begin
					bot_q <= e_q - crd_t'(1);
					if (len_c < minlen_c) begin
						rej_q  <= 1'b1;
						size_q <= '0;
					end
				end
			end
			ST_LTOP: begin
				y_q    <= top_q - s_c;
				dir_q  <= 1'b1;
				sx_q   <= cx_q;
				send_q <= ymin_q;
			end
			ST_RUP: begin
				if (e_q < top_q) begin
					top_q <= e_q + crd_t'(1);
				end
			end
			ST_LBOT: begin
				y_q    <= bot_q + s_c;
				dir_q  <= 1'b0;
				sx_q   <= cx_q;
				send_q <= yend_q;
				if (!match_c) begin
					cx_q <= cx_q - stp_c;
				end
			end
			ST_RDN: begin
				if (e_q > bot_q) begin
					bot_q <= e_q - crd_t'(1);
				end
				cx_q <= cx_q - stp_c;
			end
			ST_DONE: begin
				if (!res_valid_q || res_ready) begin
					res_q.run_size      <= size_q;
					res_q.rejected      <= rej_q;
					res_q.run_end_row   <= runend_q[8:0];
					res_q.extent_top    <= top_q[CW-1] ? 8'd0 : top_q[7:0];
					res_q.extent_bottom <= bot_q[CW-1] ? 9'd0 : bot_q[8:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_RUN;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop && q_item.op == OP_EXPLORE) begin
						ret_q   <= ST_RUN;
						state_q <= ST_SCHK;
					end
				end
				ST_SCHK: state_q <= before_c ? ST_ST1 : ret_q;
				ST_ST1:  state_q <= match_c ? ST_SCHK : ST_SINR;
				ST_SINR: state_q <= (y_q == back_q) ? ret_q : ST_ST2;
				ST_ST2:  state_q <= match_c ? ST_SCHK : ST_SINR;
				ST_RUN: begin
					if (col_q == CLS_GREEN || len_c < minlen_c) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_LCHK;
					end
				end
				ST_LCHK: state_q <= (cx_q > xmin_q) ? ST_LTOP : ST_DONE;
				ST_LTOP: begin
					if (match_c) begin
						ret_q   <= ST_RUP;
						state_q <= ST_SCHK;
					end else begin
						state_q <= ST_LBRD;
					end
				end
				ST_RUP:  state_q <= ST_LBRD;
				ST_LBRD: state_q <= ST_LBOT;
				ST_LBOT: begin
					if (match_c) begin
						ret_q   <= ST_RDN;
						state_q <= ST_SCHK;
					end else begin
						state_q <= ST_LCHK;
					end
				end
				ST_RDN:  state_q <= ST_LCHK;
				ST_DONE: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### hw/rtl/color_run_explorer_unit.sv
// Top level of the colour run explorer: configuration registers, front queue, back end.
// Depends on crx_pkg, crx_if, crx_front, crx_back and crx_ram.
//
// A write word stores one pixel class. An explore word visits frame pixels one by one, as
// the sequencer reads the single frame RAM read port and waits for its registered data,
// and may then step column by column to the left; set-up and result hand-over add to it. A
// queue of QUEUE_DEPTH words and the result register let both channels stall independently.
// The frame holds no reset state: a pixel read before it is written returns an arbitrary
// class.
module color_run_explorer_unit #(
	parameter int FRAME_WIDTH  = 512,
	parameter int FRAME_HEIGHT = 256,
	parameter int QUEUE_DEPTH  = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [crx_pkg::IDX_W-1:0]  cfg_index,
	input  logic [7:0]                 cfg_data,
	crx_cmd_if.sink                    cmd,
	crx_res_if.source                  res
);
	import crx_pkg::*;

	cfg_t     cfg_q;
	logic     q_valid, q_pop, res_valid;
	cmd_t     q_item;
	res_t     res_word;
	bk_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{explore_step: 7'd2, grid_step: 5'd4, skip_offset: 5'd2,
				min_seg_orange: 8'd2, min_seg_white: 8'd2};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EXPLORE_STEP:   cfg_q.explore_step   <= cfg_data[6:0];
				REG_GRID_STEP:      cfg_q.grid_step      <= cfg_data[4:0];
				REG_SKIP_OFFSET:    cfg_q.skip_offset    <= cfg_data[4:0];
				REG_MIN_SEG_ORANGE: cfg_q.min_seg_orange <= cfg_data;
				REG_MIN_SEG_WHITE:  cfg_q.min_seg_white  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	crx_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	crx_back #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_word  (res_word),
		.res_ready (res.ready),
		.stat      (stat)
	);

	assign res.valid         = res_valid;
	assign res.run_size      = res_word.run_size;
	assign res.rejected      = res_word.rejected;
	assign res.run_end_row   = res_word.run_end_row;
	assign res.extent_top    = res_word.extent_top;
	assign res.extent_bottom = res_word.extent_bottom;

	a_ram_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.ram_we && stat.ram_re))
		else $error("frame read and written in the same cycle");

	a_write_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		stat.ram_we |-> (q_valid && q_pop && q_item.op == OP_WRITE))
		else $error("frame written without a queued write word");

	a_rejected_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.rejected) |-> (res.run_size == '0))
		else $error("rejected run carries a size");
endmodule
